// ===== hw/rtl/tape_pulse_player_defines.svh =====
// Assertion macros for the tape pulse player.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef TAPE_PULSE_PLAYER_DEFINES_SVH
`define TAPE_PULSE_PLAYER_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define TPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tape_pulse_player: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tape_pulse_player: next-cycle check failed");

`else

`define TPP_ASSERT_NOW(label, ante, cons)
`define TPP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/tpp_pkg.sv =====
// Shared types and constants for the tape pulse player.
// No dependencies; imported by every module of the block.
`default_nettype none

package tpp_pkg;

    // Default store depth and pulse length width.
    localparam int TPP_PULSE_DEPTH = 65536;
    localparam int TPP_PULSE_BITS  = 24;

    // Item operation codes; code 7 is unused and changes nothing.
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_APPEND = 3'd1,
        OP_PLAY   = 3'd2,
        OP_STOP   = 3'd3,
        OP_MOTOR  = 3'd4,
        OP_REWIND = 3'd5,
        OP_EJECT  = 3'd6
    } tpp_op_t;

    // Single-bit status of one result.
    typedef struct packed {
        logic rise;
        logic fall;
        logic ended;
        logic playing;
        logic motor;
        logic loaded;
    } tpp_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpp_pulse_mem.sv =====
// Pulse length store: one write port, one registered read port.
// Forwards same-cycle write data to the read port. Depends on tpp_pkg.
`default_nettype none

module tpp_pulse_mem
    import tpp_pkg::*;
#(
    parameter int DEPTH = TPP_PULSE_DEPTH,
    parameter int WIDTH = TPP_PULSE_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    localparam int ADDR_BITS = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [WIDTH-1:0] bypass_data_reg;
    logic             bypass_reg;
    logic             bypass_next;

    // A write to the entry being read wins over the stale array data.
    assign bypass_next = wr_en && (wr_addr == rd_addr);

    // Array write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg        <= mem[rd_addr];
        bypass_data_reg <= wr_data;
    end

    // Bypass select flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else
        begin
            bypass_reg <= bypass_next;
        end
    end

    assign rd_data = bypass_reg ? bypass_data_reg : rd_q_reg;

    // The address width follows the depth.
    if (ADDR_BITS < 1)
    begin : g_depth_check
        $error("tpp_pulse_mem: depth must be at least two");
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpp_transport.sv =====
// Transport state and per-item update of the tape pulse player.
// Keeps the store read address on the next head entry. Depends on tpp_pkg.
`default_nettype none

module tpp_transport
    import tpp_pkg::*;
#(
    parameter int PULSE_DEPTH = TPP_PULSE_DEPTH,
    parameter int PULSE_BITS  = TPP_PULSE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 fire,
    input  wire logic [2:0]                           opcode,
    input  wire logic [PULSE_BITS-1:0]                pulse_cycles,
    input  wire logic                                 motor_value,
    input  wire logic [PULSE_BITS-1:0]                head_len,
    output logic                                      wr_en,
    output logic      [$clog2(PULSE_DEPTH)-1:0]       wr_addr,
    output logic      [PULSE_BITS-1:0]                wr_data,
    output logic      [$clog2(PULSE_DEPTH)-1:0]       rd_addr,
    output tpp_flags_t                                flags_next,
    output logic      [$clog2(PULSE_DEPTH+1)-1:0]     head_next
);

    localparam int ADDR_BITS  = $clog2(PULSE_DEPTH);
    localparam int INDEX_BITS = $clog2(PULSE_DEPTH + 1);
    localparam logic [INDEX_BITS-1:0] DEPTH_IDX = INDEX_BITS'(PULSE_DEPTH);

    logic [INDEX_BITS-1:0] head_reg;
    logic [INDEX_BITS-1:0] total_reg;
    logic [INDEX_BITS-1:0] total_next;
    logic [PULSE_BITS-1:0] rise_cnt_reg;
    logic [PULSE_BITS-1:0] rise_cnt_next;
    logic [PULSE_BITS-1:0] fall_cnt_reg;
    logic [PULSE_BITS-1:0] fall_cnt_next;
    logic                  rise_arm_reg;
    logic                  rise_arm_next;
    logic                  fall_arm_reg;
    logic                  fall_arm_next;
    logic                  play_reg;
    logic                  play_next;
    logic                  motor_reg;
    logic                  motor_next;

    logic                  loaded;
    logic                  has_next;
    logic                  sched;
    logic                  rise_hit;
    logic                  fall_hit;
    logic                  ended;
    logic [PULSE_BITS-1:0] rise_dec;
    logic [PULSE_BITS-1:0] fall_dec;
    logic [PULSE_BITS-1:0] half_len;

    assign loaded   = (total_reg != '0);
    assign has_next = (head_reg < total_reg);
    assign rise_dec = rise_cnt_reg - 1'b1;
    assign fall_dec = fall_cnt_reg - 1'b1;
    assign half_len = head_len >> 1;

    // Store write: appends go to the entry just past the tape end.
    assign wr_addr = total_reg[ADDR_BITS-1:0];
    assign wr_data = pulse_cycles;

    // Next-state logic for one transferred item.
    always_comb
    begin
        head_next     = head_reg;
        total_next    = total_reg;
        rise_cnt_next = rise_cnt_reg;
        fall_cnt_next = fall_cnt_reg;
        rise_arm_next = rise_arm_reg;
        fall_arm_next = fall_arm_reg;
        play_next     = play_reg;
        motor_next    = motor_reg;
        wr_en         = 1'b0;
        sched         = 1'b0;
        rise_hit      = 1'b0;
        fall_hit      = 1'b0;
        ended         = 1'b0;

        if (fire)
        begin
            unique case (tpp_op_t'(opcode))
                OP_TICK:
                begin
                    if (loaded && play_reg && motor_reg)
                    begin
                        if (rise_arm_reg)
                        begin
                            rise_cnt_next = rise_dec;
                            if (rise_dec == '0)
                            begin
                                rise_hit      = 1'b1;
                                rise_arm_next = 1'b0;
                            end
                        end
                        if (fall_arm_reg)
                        begin
                            fall_cnt_next = fall_dec;
                            if (fall_dec == '0)
                            begin
                                fall_hit      = 1'b1;
                                fall_arm_next = 1'b0;
                                if (has_next)
                                begin
                                    sched = 1'b1;
                                end
                                else
                                begin
                                    play_next  = 1'b0;
                                    motor_next = 1'b0;
                                    ended      = 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_APPEND:
                begin
                    if (total_reg < DEPTH_IDX)
                    begin
                        wr_en      = 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                end
                OP_PLAY:
                begin
                    if (loaded)
                    begin
                        play_next = 1'b1;
                        sched     = has_next;
                    end
                end
                OP_STOP:
                begin
                    play_next  = 1'b0;
                    motor_next = 1'b0;
                end
                OP_MOTOR:
                begin
                    motor_next = motor_value;
                end
                OP_REWIND:
                begin
                    head_next = '0;
                end
                OP_EJECT:
                begin
                    if (loaded)
                    begin
                        play_next  = 1'b0;
                        motor_next = 1'b0;
                        head_next  = '0;
                        total_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Scheduling loads the head pulse over any countdown update above.
        if (sched)
        begin
            rise_cnt_next = half_len;
            fall_cnt_next = head_len;
            rise_arm_next = (half_len != '0);
            fall_arm_next = (head_len != '0);
            head_next     = head_reg + 1'b1;
        end
    end

    // Read ahead so the head entry is ready on the next item.
    always_comb
    begin
        if (head_next < DEPTH_IDX)
        begin
            rd_addr = head_next[ADDR_BITS-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Status after the item.
    assign flags_next.rise    = rise_hit;
    assign flags_next.fall    = fall_hit;
    assign flags_next.ended   = ended;
    assign flags_next.playing = play_next;
    assign flags_next.motor   = motor_next;
    assign flags_next.loaded  = (total_next != '0);

    // Transport state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            total_reg    <= '0;
            rise_cnt_reg <= '0;
            fall_cnt_reg <= '0;
            rise_arm_reg <= 1'b0;
            fall_arm_reg <= 1'b0;
            play_reg     <= 1'b0;
            motor_reg    <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            total_reg    <= total_next;
            rise_cnt_reg <= rise_cnt_next;
            fall_cnt_reg <= fall_cnt_next;
            rise_arm_reg <= rise_arm_next;
            fall_arm_reg <= fall_arm_next;
            play_reg     <= play_next;
            motor_reg    <= motor_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tape_pulse_player.sv =====
// Tape pulse player: plays a stored tape of pulse lengths as a square wave.
//
// Input channel (in_valid/in_ready) carries one command per transfer: tick,
// append pulse, play, stop, set motor, rewind or eject. Every command gives
// exactly one result on the output channel (out_valid/out_ready) with the
// edge flags of a tick and the transport status after the command.
// A result is registered at the edge that takes its command. Throughput
// is one command per cycle while the receiver does not stall; the state
// update and the read of the next head entry from the single-port-read
// pulse store keep pace, the store read being issued one command ahead.
// The output register holds a result while the receiver stalls; in_ready
// stays high whenever the register is empty or is being emptied, so a new
// command is taken in the same cycle as the waiting result is transferred.
// Reset clears the transport state and the result valid flag. The pulse
// store is not cleared; only entries written since the last eject or reset are used.
// Depends on tpp_pkg, tpp_pulse_mem, tpp_transport and the defines header.
`default_nettype none

`include "tape_pulse_player_defines.svh"

module tape_pulse_player
    import tpp_pkg::*;
#(
    parameter int PULSE_DEPTH = TPP_PULSE_DEPTH,
    parameter int PULSE_BITS  = TPP_PULSE_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [2:0]                       opcode,
    input  wire logic [PULSE_BITS-1:0]            pulse_cycles,
    input  wire logic                             motor_value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  rising_edge,
    output logic                                  falling_edge,
    output logic                                  tape_ended,
    output logic                                  playing,
    output logic                                  motor_on,
    output logic      [$clog2(PULSE_DEPTH+1)-1:0] head_position,
    output logic                                  tape_loaded
);

    localparam int ADDR_BITS  = $clog2(PULSE_DEPTH);
    localparam int INDEX_BITS = $clog2(PULSE_DEPTH + 1);

    logic                  in_fire;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tpp_flags_t            flags_reg;
    tpp_flags_t            flags_next;
    logic [INDEX_BITS-1:0] head_pos_reg;
    logic [INDEX_BITS-1:0] head_next;

    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [PULSE_BITS-1:0] wr_data;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [PULSE_BITS-1:0] head_len;

    // Handshake: take a command whenever the result register frees up.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Pulse store.
    tpp_pulse_mem #(
        .DEPTH (PULSE_DEPTH),
        .WIDTH (PULSE_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (head_len)
    );

    // Transport control.
    tpp_transport #(
        .PULSE_DEPTH (PULSE_DEPTH),
        .PULSE_BITS  (PULSE_BITS)
    ) u_transport (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .opcode       (opcode),
        .pulse_cycles (pulse_cycles),
        .motor_value  (motor_value),
        .head_len     (head_len),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .flags_next   (flags_next),
        .head_next    (head_next)
    );

    // Result valid flag.
    always_comb
    begin
        priority if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded on each command transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            flags_reg    <= flags_next;
            head_pos_reg <= head_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rising_edge   = flags_reg.rise;
    assign falling_edge  = flags_reg.fall;
    assign tape_ended    = flags_reg.ended;
    assign playing       = flags_reg.playing;
    assign motor_on      = flags_reg.motor;
    assign head_position = head_pos_reg;
    assign tape_loaded   = flags_reg.loaded;

    // End of tape releases both keys and comes with the last falling edge.
    `TPP_ASSERT_NOW(a_end_stops, out_valid_reg && flags_reg.ended, !flags_reg.playing && !flags_reg.motor && flags_reg.fall)
    // An empty tape always has its head at the start.
    `TPP_ASSERT_NOW(a_empty_head, out_valid_reg && !flags_reg.loaded, head_pos_reg == '0)
    // A stop command reports both keys released.
    `TPP_ASSERT_NEXT(a_stop_keys, in_fire && (opcode == OP_STOP), out_valid_reg && !flags_reg.playing && !flags_reg.motor)
    // Only a tick can flag an edge.
    `TPP_ASSERT_NEXT(a_edge_tick, in_fire && (opcode != OP_TICK), !flags_reg.rise && !flags_reg.fall && !flags_reg.ended)

endmodule

`default_nettype wire
